/* src/mse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg
// Opcodes, function codes, item kinds and shared types of the MIPS subset
// executor.
// ----------------------------------------------------------------------------
package mse_pkg;

   // item kinds
   localparam logic [1:0] KIND_EXEC   = 2'd0;
   localparam logic [1:0] KIND_MEM_WR = 2'd1;
   localparam logic [1:0] KIND_MEM_RD = 2'd2;
   localparam logic [1:0] KIND_REG_RD = 2'd3;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SW      = 6'h2B;

   // function codes of the special opcode
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_MFHI = 6'h10;
   localparam logic [5:0] FN_MFLO = 6'h12;
   localparam logic [5:0] FN_MULT = 6'h18;
   localparam logic [5:0] FN_DIV  = 6'h1A;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_SLT  = 6'h2A;
   localparam logic [5:0] FN_MOVE = 6'h2F;

   localparam logic [4:0] REG_RA = 5'd31;

   // dividend width of the shared unit (offset address sum)
   localparam int UNIT_DVD_W = 34;

   typedef enum logic [1:0] {
      UOP_MUL = 2'd0,
      UOP_DIV = 2'd1,
      UOP_MOD = 2'd2
   } mse_uop_type;

   typedef struct packed {
      logic        start;
      mse_uop_type uop;
   } mse_unit_ctl_type;

   typedef struct packed {
      logic        done;
      logic [31:0] hi;
      logic [31:0] lo;
   } mse_unit_sts_type;

endpackage

/* src/mse_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse channel interfaces
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
interface mse_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [31:0]        instruction;
   logic [9:0]         mem_address;
   logic signed [31:0] write_data;
   logic [4:0]         reg_index;

   modport source (output valid, kind, instruction, mem_address, write_data, reg_index,
                   input ready);
   modport sink   (input valid, kind, instruction, mem_address, write_data, reg_index,
                   output ready);
endinterface

interface mse_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        pc_after;
   logic signed [31:0] read_data;
   logic               unsupported;

   modport source (output valid, pc_after, read_data, unsupported, input ready);
   modport sink   (input valid, pc_after, read_data, unsupported, output ready);
endinterface

/* src/mse_seq_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_seq_unit
// Shared iterative unit: signed multiply (shift-add), signed divide and
// unsigned remainder (restoring), one bit per cycle, then a sign fix step.
// ----------------------------------------------------------------------------
module mse_seq_unit import mse_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  mse_unit_ctl_type        ctl,
   input  logic [UNIT_DVD_W-1:0]   opnd_a,
   input  logic [31:0]             opnd_b,
   output mse_unit_sts_type        sts
);

   logic                  run_ff, run_in;
   logic                  fix_ff, fix_in;
   logic                  done_ff, done_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [32:0]           acc_ff, acc_in;
   logic [UNIT_DVD_W-1:0] sh_ff, sh_in;
   logic [31:0]           dsr_ff, dsr_in;
   mse_uop_type           uop_ff, uop_in;
   logic                  neg_q_ff, neg_q_in;
   logic                  neg_r_ff, neg_r_in;
   logic [31:0]           hi_ff, hi_in;
   logic [31:0]           lo_ff, lo_in;

   logic [31:0] a32;
   logic [31:0] abs_a;
   logic [31:0] abs_b;
   logic [32:0] sum;
   logic [32:0] rem_sh;
   logic [32:0] diff;
   logic [63:0] prod;

   assign a32   = opnd_a[31:0];
   assign abs_a = a32[31] ? (~a32 + 32'd1) : a32;
   assign abs_b = opnd_b[31] ? (~opnd_b + 32'd1) : opnd_b;

   assign sum    = acc_ff + (sh_ff[0] ? {1'b0, dsr_ff} : 33'd0);
   assign rem_sh = {acc_ff[31:0], sh_ff[UNIT_DVD_W-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};
   assign prod   = {acc_ff[31:0], sh_ff[31:0]};

   always_comb begin
      run_in   = run_ff;
      fix_in   = 1'b0;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      sh_in    = sh_ff;
      dsr_in   = dsr_ff;
      uop_in   = uop_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      if (ctl.start) begin
         run_in   = 1'b1;
         uop_in   = ctl.uop;
         acc_in   = 33'd0;
         neg_q_in = a32[31] ^ opnd_b[31];
         neg_r_in = a32[31];
         case (ctl.uop)
            UOP_MUL: begin
               sh_in  = {2'b00, abs_b};
               dsr_in = abs_a;
               cnt_in = 6'd32;
            end
            UOP_DIV: begin
               sh_in  = {2'b00, abs_a};
               dsr_in = abs_b;
               cnt_in = 6'(UNIT_DVD_W);
            end
            default: begin
               sh_in    = opnd_a;
               dsr_in   = opnd_b;
               neg_q_in = 1'b0;
               neg_r_in = 1'b0;
               cnt_in   = 6'(UNIT_DVD_W);
            end
         endcase
      end else if (run_ff) begin
         if (uop_ff == UOP_MUL) begin
            acc_in = {1'b0, sum[32:1]};
            sh_in  = {2'b00, sum[0], sh_ff[31:1]};
         end else if (!diff[32]) begin
            acc_in = diff;
            sh_in  = {sh_ff[UNIT_DVD_W-2:0], 1'b1};
         end else begin
            acc_in = rem_sh;
            sh_in  = {sh_ff[UNIT_DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in = 1'b0;
            fix_in = 1'b1;
         end
      end else if (fix_ff) begin
         done_in = 1'b1;
         case (uop_ff)
            UOP_MUL: begin
               hi_in = neg_q_ff ? (~prod[63:32] + 32'(prod[31:0] == 32'd0)) : prod[63:32];
               lo_in = neg_q_ff ? (~prod[31:0] + 32'd1) : prod[31:0];
            end
            UOP_DIV: begin
               lo_in = neg_q_ff ? (~sh_ff[31:0] + 32'd1) : sh_ff[31:0];
               hi_in = neg_r_ff ? (~acc_ff[31:0] + 32'd1) : acc_ff[31:0];
            end
            default: begin
               lo_in = acc_ff[31:0];
               hi_in = 32'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         run_ff  <= run_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      sh_ff    <= sh_in;
      dsr_ff   <= dsr_in;
      uop_ff   <= uop_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign sts.done = done_ff;
   assign sts.hi   = hi_ff;
   assign sts.lo   = lo_ff;

endmodule

/* src/mips_subset_instruction_executor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor_unit
// Executes one MIPS subset instruction or one storage access per item.
// ----------------------------------------------------------------------------
// After reset the data memory is swept to zero, one word per cycle, so no item
// is taken until the sweep is done. Items are then handled one at a time.
// Mult and div run one bit per cycle in the shared iterative unit; a div by
// zero finishes without starting it. Every memory access (lw, sw and the
// direct memory kinds) first reduces its word index modulo MEM_WORDS with a
// reciprocal multiply, a subtraction and a final correction, then writes or
// reads the memory. A finished result waits in the output register while the
// next item is accepted.
module mips_subset_instruction_executor_unit import mse_pkg::*; #(
   parameter int MEM_WORDS = 1024
) (
   input logic        clock,
   input logic        reset,
   mse_req_if.sink    req_bus,
   mse_rsp_if.source  rsp_bus
);

   localparam int IDX_W = $clog2(MEM_WORDS);
   localparam longint unsigned MOD_OFFSET_L = longint'(MEM_WORDS) *
      (((longint'(1) << 32) + longint'(MEM_WORDS) - 1) / longint'(MEM_WORDS));
   localparam logic [UNIT_DVD_W-1:0] MOD_OFFSET = UNIT_DVD_W'(MOD_OFFSET_L);
   localparam logic [31:0] MOD_RECIP = 32'((longint'(1) << UNIT_DVD_W) / longint'(MEM_WORDS));
   localparam logic [16:0] MOD_M17   = 17'(MEM_WORDS);
   localparam logic [17:0] MOD_M18   = 18'(MEM_WORDS);
   localparam logic [17:0] MOD_2M18  = 18'(2 * MEM_WORDS);

   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_READ    = 9'b000000100,
      ST_EXEC    = 9'b000001000,
      ST_MDWAIT  = 9'b000010000,
      ST_MODWAIT = 9'b000100000,
      ST_MEMACC  = 9'b001000000,
      ST_MEMRD   = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // latched item
   logic [1:0]  kind_ff;
   logic [31:0] ins_ff;
   logic [9:0]  maddr_ff;
   logic [31:0] wdata_ff;
   logic [4:0]  ridx_ff;

   // architectural state
   logic [31:0] regs_ff [32];
   logic [31:0] rv_ff;
   logic [31:0] mem_ff [MEM_WORDS];
   logic [31:0] hi_ff, hi_in;
   logic [31:0] lo_ff, lo_in;
   logic [31:0] pc_ff, pc_in;

   logic [31:0]      rf_a_ff, rf_b_ff;
   logic [31:0]      mem_q_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [31:0]      res_data_ff, res_data_in;
   logic             res_bad_ff, res_bad_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_pc_ff, rsp_pc_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        rsp_bad_ff, rsp_bad_in;

   // index reduction: estimate quotient, subtract, then fix up by at most 2*MEM_WORDS
   logic [UNIT_DVD_W-1:0] mod_x_ff, mod_x_in;
   logic [1:0]            mod_cnt_ff, mod_cnt_in;
   logic [63:0]           mod_prod;
   logic [31:0]           mod_q_ff, mod_q_in;
   logic [48:0]           mod_qm;
   logic [17:0]           mod_r_ff, mod_r_in;
   logic [17:0]           mod_fix;

   logic             rf_we;
   logic [4:0]       rf_wa;
   logic [31:0]      rf_wd;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [31:0]      mem_wd;

   mse_unit_ctl_type      unit_ctl;
   mse_unit_sts_type      unit_sts;
   logic [UNIT_DVD_W-1:0] unit_a;
   logic [31:0]           unit_b;

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd;
   logic [31:0] imm;
   logic [4:0]  rda;
   logic [31:0] pc_inc;
   logic [32:0] addr_sum;
   logic        is_mem_write;
   logic        accept;

   assign op     = ins_ff[31:26];
   assign rs     = ins_ff[25:21];
   assign rt     = ins_ff[20:16];
   assign rd     = ins_ff[15:11];
   assign fn     = ins_ff[5:0];
   assign imm    = {{16{ins_ff[15]}}, ins_ff[15:0]};
   assign pc_inc = pc_ff + 32'd4;
   assign addr_sum = {rf_a_ff[31], rf_a_ff} + {imm[31], imm};
   assign is_mem_write = (kind_ff == KIND_MEM_WR) ||
                         (kind_ff == KIND_EXEC && op == OP_SW);

   assign mod_prod = {32'd0, mod_x_ff[UNIT_DVD_W-1:2]} * {32'd0, MOD_RECIP};
   assign mod_q_in = mod_prod[63:32];
   assign mod_qm   = {17'd0, mod_q_ff} * {32'd0, MOD_M17};
   assign mod_r_in = 18'(mod_x_ff - mod_qm[UNIT_DVD_W-1:0]);
   assign mod_fix  = (mod_r_ff >= MOD_2M18) ? (mod_r_ff - MOD_2M18) :
                     ((mod_r_ff >= MOD_M18) ? (mod_r_ff - MOD_M18) : mod_r_ff);

   // jr reads the return register on port a
   assign rda = (kind_ff == KIND_REG_RD) ? ridx_ff :
                ((op == OP_SPECIAL && fn == FN_JR) ? REG_RA : rs);

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   mse_seq_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctl    (unit_ctl),
      .opnd_a (unit_a),
      .opnd_b (unit_b),
      .sts    (unit_sts)
   );

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      idx_in       = idx_ff;
      clr_cnt_in   = clr_cnt_ff;
      res_data_in  = res_data_ff;
      res_bad_in   = res_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pc_in    = rsp_pc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_bad_in   = rsp_bad_ff;
      mod_x_in     = mod_x_ff;
      mod_cnt_in   = mod_cnt_ff;
      rf_we        = 1'b0;
      rf_wa        = rd;
      rf_wd        = 32'd0;
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_wd       = (kind_ff == KIND_MEM_WR) ? wdata_ff : rf_b_ff;
      unit_ctl     = '{start: 1'b0, uop: UOP_MUL};
      unit_a       = {2'b00, rf_a_ff};
      unit_b       = rf_b_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            mem_wd     = 32'd0;
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == IDX_W'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in    = ST_DONE;
            res_data_in = 32'd0;
            res_bad_in  = 1'b0;
            if (kind_ff == KIND_REG_RD) begin
               res_data_in = rf_a_ff;
            end else if (kind_ff inside {KIND_MEM_WR, KIND_MEM_RD}) begin
               mod_x_in   = {{(UNIT_DVD_W-10){1'b0}}, maddr_ff};
               mod_cnt_in = 2'd0;
               state_in   = ST_MODWAIT;
            end else begin
               pc_in = pc_inc;
               case (op)
                  OP_SPECIAL: begin
                     case (fn)
                        FN_ADD:  begin rf_we = 1'b1; rf_wd = rf_a_ff + rf_b_ff; end
                        FN_SUB:  begin rf_we = 1'b1; rf_wd = rf_a_ff - rf_b_ff; end
                        FN_AND:  begin rf_we = 1'b1; rf_wd = rf_a_ff & rf_b_ff; end
                        FN_OR:   begin rf_we = 1'b1; rf_wd = rf_a_ff | rf_b_ff; end
                        FN_SLT: begin
                           rf_we = 1'b1;
                           rf_wd = {31'd0, $signed(rf_a_ff) < $signed(rf_b_ff)};
                        end
                        FN_MFHI: begin rf_we = 1'b1; rf_wd = hi_ff; end
                        FN_MFLO: begin rf_we = 1'b1; rf_wd = lo_ff; end
                        FN_MOVE: begin rf_we = 1'b1; rf_wd = rf_a_ff; end
                        FN_JR:   pc_in = rf_a_ff;
                        FN_MULT: begin
                           unit_ctl = '{start: 1'b1, uop: UOP_MUL};
                           unit_a   = {2'b00, rf_a_ff};
                           unit_b   = rf_b_ff;
                           state_in = ST_MDWAIT;
                        end
                        FN_DIV: begin
                           // zero divisor leaves hi and lo alone
                           if (rf_b_ff != 32'd0) begin
                              unit_ctl = '{start: 1'b1, uop: UOP_DIV};
                              unit_a   = {2'b00, rf_a_ff};
                              unit_b   = rf_b_ff;
                              state_in = ST_MDWAIT;
                           end
                        end
                        default: res_bad_in = 1'b1;
                     endcase
                  end
                  OP_LW, OP_SW: begin
                     // offset keeps the signed index positive before the remainder
                     mod_x_in   = {addr_sum[32], addr_sum} + MOD_OFFSET;
                     mod_cnt_in = 2'd0;
                     state_in   = ST_MODWAIT;
                  end
                  OP_BEQ: begin
                     if (rf_a_ff == rf_b_ff) begin
                        pc_in = pc_inc + {imm[29:0], 2'b00};
                     end
                  end
                  OP_ADDI: begin
                     rf_we = 1'b1;
                     rf_wa = rt;
                     rf_wd = rf_a_ff + imm;
                  end
                  OP_J: pc_in = {4'd0, ins_ff[25:0], 2'b00};
                  OP_JAL: begin
                     rf_we = 1'b1;
                     rf_wa = REG_RA;
                     rf_wd = pc_inc;
                     pc_in = {4'd0, ins_ff[25:0], 2'b00};
                  end
                  default: res_bad_in = 1'b1;
               endcase
            end
         end
         ST_MDWAIT: begin
            if (unit_sts.done) begin
               hi_in    = unit_sts.hi;
               lo_in    = unit_sts.lo;
               state_in = ST_DONE;
            end
         end
         ST_MODWAIT: begin
            // quotient estimate, then difference, then final correction
            mod_cnt_in = mod_cnt_ff + 2'd1;
            if (mod_cnt_ff == 2'd2) begin
               idx_in   = mod_fix[IDX_W-1:0];
               state_in = ST_MEMACC;
            end
         end
         ST_MEMACC: begin
            if (is_mem_write) begin
               mem_we   = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_MEMRD;
            end
         end
         ST_MEMRD: begin
            if (kind_ff == KIND_MEM_RD) begin
               res_data_in = mem_q_ff;
            end else begin
               rf_we = 1'b1;
               rf_wa = rt;
               rf_wd = mem_q_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pc_in    = pc_ff;
               rsp_data_in  = res_data_ff;
               rsp_bad_in   = res_bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         pc_ff        <= 32'd0;
         hi_ff        <= 32'd0;
         lo_ff        <= 32'd0;
         rv_ff        <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pc_ff        <= pc_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rf_we && rf_wa != 5'd0) begin
            rv_ff[rf_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_bus.kind;
         ins_ff   <= req_bus.instruction;
         maddr_ff <= req_bus.mem_address;
         wdata_ff <= req_bus.write_data;
         ridx_ff  <= req_bus.reg_index;
      end
      idx_ff      <= idx_in;
      res_data_ff <= res_data_in;
      res_bad_ff  <= res_bad_in;
      rsp_pc_ff   <= rsp_pc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_bad_ff  <= rsp_bad_in;
      mod_x_ff    <= mod_x_in;
      mod_cnt_ff  <= mod_cnt_in;
      mod_q_ff    <= mod_q_in;
      mod_r_ff    <= mod_r_in;
   end

   // register file: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (rf_we && rf_wa != 5'd0) begin
         regs_ff[rf_wa] <= rf_wd;
      end
      rf_a_ff <= rv_ff[rda] ? regs_ff[rda] : 32'd0;
      rf_b_ff <= rv_ff[rt] ? regs_ff[rt] : 32'd0;
   end

   // data memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem_ff[idx_ff];
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pc_after    = rsp_pc_ff;
   assign rsp_bus.read_data   = rsp_data_ff;
   assign rsp_bus.unsupported = rsp_bad_ff;

   a_unit_start_exec: assert property (@(posedge clock) disable iff (reset)
      unit_ctl.start |-> state_ff == ST_EXEC)
      else $error("shared unit started outside execute");

   a_unit_done_wait: assert property (@(posedge clock) disable iff (reset)
      unit_sts.done |-> state_ff == ST_MDWAIT)
      else $error("shared unit finished with nobody waiting");

   a_reg_zero: assert property (@(posedge clock) disable iff (reset)
      !rv_ff[0])
      else $error("register zero was written");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done");

   a_pc_from_exec: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && pc_ff != $past(pc_ff)) |-> $past(state_ff == ST_EXEC))
      else $error("pc changed outside execute");

endmodule
